// File: rtl/core/assm_pkg.sv
// Shared types and constants for the adaptive steering smoother.
`default_nettype none

package assm_pkg;

  // Sequencer states of the smoother.
  typedef enum logic [2:0] {
    S_IDLE,
    S_DIV,
    S_BLEND,
    S_ALPHA,
    S_STEP,
    S_FIN
  } state_e;

  // Configuration register indexes.
  localparam int unsigned CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_STRAIGHT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN_TURN     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TURN_ANGLE    = 2'd2;

  // Controls handed from the sequencer to the shared multiplier.
  typedef struct packed {
    logic en;
    logic sel_step;
  } mul_ctrl_t;

endpackage

`default_nettype wire

// File: rtl/core/assm_mul.sv
// Shared registered multiplier for the gain blend and the filter step.
`default_nettype none

module assm_mul #(
  parameter int unsigned STEER_WIDTH    = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  wire                    clk_i,
  input  assm_pkg::mul_ctrl_t    ctrl_i,
  input  wire  [GAIN_FRAC_BITS+1:0] diff_i,
  input  wire  [GAIN_FRAC_BITS:0]   ratio_i,
  input  wire  [STEER_WIDTH:0]      dmag_i,
  input  wire  [GAIN_FRAC_BITS:0]   alpha_i,
  output logic signed [((GAIN_FRAC_BITS > STEER_WIDTH) ? GAIN_FRAC_BITS : STEER_WIDTH)
                       + GAIN_FRAC_BITS + 3:0] prod_o
);

  localparam int unsigned MA = ((GAIN_FRAC_BITS > STEER_WIDTH) ? GAIN_FRAC_BITS : STEER_WIDTH)
                               + 2;
  localparam int unsigned MB = GAIN_FRAC_BITS + 2;
  localparam int unsigned PW = MA + MB;

  logic signed [GAIN_FRAC_BITS+1:0] diff_s;
  logic signed [MA-1:0] op_a;
  logic signed [MB-1:0] op_b;

  // Operand selection: the gain difference times the ratio, or alpha times the error.
  always_comb begin
    diff_s = $signed(diff_i);
    if (ctrl_i.sel_step) begin
      op_a = $signed(MA'(dmag_i));
      op_b = $signed(MB'(alpha_i));
    end else begin
      op_a = MA'(diff_s);
      op_b = $signed(MB'(ratio_i));
    end
  end

  // Product register.
  always_ff @(posedge clk_i) begin
    if (ctrl_i.en) begin
      prod_o <= PW'(op_a * op_b);
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/adaptive_steering_smoother.sv
// Adaptive steering smoother: gain-blended first-order low-pass on steering samples.
// An accepted item runs the ratio divider, one quotient bit per cycle, then the blend, alpha,
// step and finish states; the divide is skipped when the magnitude reaches the turn angle.
// The input is not ready while an item is at work, and a finished result waits for a free
// output register, so a new item is taken only after the last one is through.
// Reset loads the register defaults and clears the filter state, as does any register write.
`default_nettype none

module adaptive_steering_smoother #(
  parameter int unsigned STEER_WIDTH    = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  output logic                         in_ready_o,
  input  wire  signed [STEER_WIDTH-1:0] command_value_i,
  input  wire                          command_ok_i,
  input  wire  signed [STEER_WIDTH-1:0] measured_value_i,
  input  wire                          measured_ok_i,
  input  wire                          seq_first_i,
  output logic                         out_valid_o,
  input  wire                          out_ready_i,
  output logic signed [STEER_WIDTH-1:0] smoothed_value_o,
  input  wire                          cfg_we_i,
  input  wire  [assm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [((GAIN_FRAC_BITS + 1 > STEER_WIDTH - 1) ? GAIN_FRAC_BITS + 1 : STEER_WIDTH - 1)
                - 1:0] cfg_data_i
);

  localparam int unsigned SW   = STEER_WIDTH;
  localparam int unsigned G    = GAIN_FRAC_BITS;
  localparam int unsigned GW   = G + 1;
  localparam int unsigned ANW  = SW - 1;
  localparam int unsigned MA   = ((G > SW) ? G : SW) + 2;
  localparam int unsigned PW   = MA + G + 2;
  localparam int unsigned CNTW = $clog2(G);

  // Register defaults: 0.1 straight gain, 0.5 turn gain, 0.5 rad turn angle.
  localparam logic [GW-1:0]  GS_RST = GW'((64'd6554 << G) >> 16);
  localparam logic [GW-1:0]  GT_RST = GW'(64'd1 << (G - 1));
  localparam logic [ANW-1:0] TA_RST = ANW'(64'd1 << (SW - 5));
  localparam logic [PW-1:0]  HALF   = PW'(64'd1 << (G - 1));

  assm_pkg::state_e state_q, state_d;

  logic [GW-1:0]  gs_q, gt_q;
  logic [ANW-1:0] ta_q;

  logic signed [SW-1:0] running_q, saved_q, prev_q, out_data_q;
  logic has_hist_q, first_q, out_valid_q;
  logic [SW:0]     dmag_q;
  logic            dneg_q;
  logic [ANW-1:0]  rem_q;
  logic [G:0]      quot_q;
  logic [CNTW-1:0] cnt_q;
  logic [G:0]      alpha_q;

  logic signed [PW-1:0] prod;
  assm_pkg::mul_ctrl_t  mul_ctrl;

  logic in_fire, out_slot, fin_fire, cfg_hit;

  // Sample front end: starting value, target and magnitudes.
  logic signed [SW-1:0] start_v, prev_v, target_v;
  logic [SW:0]   tneg, pneg, tmag_w, pmag_w;
  logic [SW-1:0] mag_v;
  logic signed [SW+1:0] dx;
  logic [SW+1:0] dneg_w;

  always_comb begin
    start_v  = has_hist_q ? saved_q : (measured_ok_i ? measured_value_i : '0);
    prev_v   = seq_first_i ? start_v : running_q;
    target_v = command_ok_i ? command_value_i : prev_v;
    tneg     = -{target_v[SW-1], target_v};
    pneg     = -{prev_v[SW-1], prev_v};
    tmag_w   = target_v[SW-1] ? tneg : {target_v[SW-1], target_v};
    pmag_w   = prev_v[SW-1] ? pneg : {prev_v[SW-1], prev_v};
    mag_v    = (tmag_w > pmag_w) ? tmag_w[SW-1:0] : pmag_w[SW-1:0];
    dx       = {{2{target_v[SW-1]}}, target_v} - {{2{prev_v[SW-1]}}, prev_v};
    dneg_w   = -dx;
  end

  // Restoring divider step: one quotient bit per cycle.
  logic [SW-1:0] rem_sh, rem_sub;
  logic          div_ge;

  always_comb begin
    rem_sh  = {rem_q, 1'b0};
    div_ge  = rem_sh >= SW'(ta_q);
    rem_sub = rem_sh - SW'(ta_q);
  end

  // Alpha from the blended gain, clamped at zero and rounded half up.
  logic signed [PW-1:0] blend, blend_rnd;
  logic [G:0] alpha_d;

  always_comb begin
    blend     = $signed(PW'({gs_q, {G{1'b0}}})) + prod;
    blend_rnd = blend + $signed(HALF);
    alpha_d   = blend[PW-1] ? '0 : blend_rnd[2*G:G];
  end

  // Filter step: round the scaled error, apply its sign, saturate.
  logic [PW-1:0]        step_rnd;
  logic [SW+1:0]        stepm;
  logic signed [SW+2:0] res_w;
  logic signed [SW-1:0] res_v;

  always_comb begin
    step_rnd = $unsigned(prod) + HALF;
    stepm    = step_rnd[G+SW+1:G];
    res_w    = dneg_q ? ({{3{prev_q[SW-1]}}, prev_q} - {1'b0, stepm})
                      : ({{3{prev_q[SW-1]}}, prev_q} + {1'b0, stepm});
    if (res_w[SW+2:SW-1] == '0 || res_w[SW+2:SW-1] == '1) begin
      res_v = res_w[SW-1:0];
    end else if (res_w[SW+2]) begin
      res_v = {1'b1, {(SW-1){1'b0}}};
    end else begin
      res_v = {1'b0, {(SW-1){1'b1}}};
    end
  end

  assign in_ready_o = (state_q == assm_pkg::S_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign out_slot   = !out_valid_q || out_ready_i;
  assign fin_fire   = (state_q == assm_pkg::S_FIN) && out_slot;
  assign cfg_hit    = cfg_we_i && (cfg_index_i == assm_pkg::CFG_GAIN_STRAIGHT ||
                                   cfg_index_i == assm_pkg::CFG_GAIN_TURN ||
                                   cfg_index_i == assm_pkg::CFG_TURN_ANGLE);

  // Sequencer next state and multiplier controls.
  always_comb begin
    state_d           = state_q;
    mul_ctrl.en       = 1'b0;
    mul_ctrl.sel_step = 1'b0;
    unique case (state_q)
      assm_pkg::S_IDLE: begin
        if (in_valid_i) begin
          state_d = (mag_v >= SW'(ta_q)) ? assm_pkg::S_BLEND : assm_pkg::S_DIV;
        end
      end
      assm_pkg::S_DIV: begin
        if (cnt_q == CNTW'(G - 1)) begin
          state_d = assm_pkg::S_BLEND;
        end
      end
      assm_pkg::S_BLEND: begin
        mul_ctrl.en = 1'b1;
        state_d     = assm_pkg::S_ALPHA;
      end
      assm_pkg::S_ALPHA: begin
        state_d = assm_pkg::S_STEP;
      end
      assm_pkg::S_STEP: begin
        mul_ctrl.en       = 1'b1;
        mul_ctrl.sel_step = 1'b1;
        state_d           = assm_pkg::S_FIN;
      end
      assm_pkg::S_FIN: begin
        if (out_slot) begin
          state_d = assm_pkg::S_IDLE;
        end
      end
      default: state_d = assm_pkg::S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= assm_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gs_q <= GS_RST;
      gt_q <= GT_RST;
      ta_q <= TA_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        assm_pkg::CFG_GAIN_STRAIGHT: gs_q <= cfg_data_i[GW-1:0];
        assm_pkg::CFG_GAIN_TURN:     gt_q <= cfg_data_i[GW-1:0];
        assm_pkg::CFG_TURN_ANGLE:    ta_q <= cfg_data_i[ANW-1:0];
        default: ;
      endcase
    end
  end

  // Filter state: cleared by reset and by register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      running_q  <= '0;
      saved_q    <= '0;
      has_hist_q <= 1'b0;
    end else if (cfg_hit) begin
      running_q  <= '0;
      saved_q    <= '0;
      has_hist_q <= 1'b0;
    end else if (fin_fire) begin
      running_q <= res_v;
      if (first_q) begin
        saved_q    <= res_v;
        has_hist_q <= 1'b1;
      end
    end
  end

  // Per-item working registers and the divider.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      prev_q  <= prev_v;
      first_q <= seq_first_i;
      dneg_q  <= dx[SW+1];
      dmag_q  <= dx[SW+1] ? dneg_w[SW:0] : dx[SW:0];
      rem_q   <= mag_v[ANW-1:0];
      cnt_q   <= '0;
      quot_q  <= (mag_v >= SW'(ta_q)) ? {1'b1, {G{1'b0}}} : '0;
    end else if (state_q == assm_pkg::S_DIV) begin
      rem_q  <= div_ge ? rem_sub[ANW-1:0] : rem_sh[ANW-1:0];
      quot_q <= {quot_q[G-1:0], div_ge};
      cnt_q  <= cnt_q + 1'b1;
    end
    if (state_q == assm_pkg::S_ALPHA) begin
      alpha_q <= alpha_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_fire) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_fire) begin
      out_data_q <= res_v;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign smoothed_value_o = out_data_q;

  // Shared multiplier.
  assm_mul #(
    .STEER_WIDTH   (STEER_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) u_mul (
    .clk_i  (clk_i),
    .ctrl_i (mul_ctrl),
    .diff_i ({1'b0, gt_q} - {1'b0, gs_q}),
    .ratio_i(quot_q),
    .dmag_i (dmag_q),
    .alpha_i(alpha_q),
    .prod_o (prod)
  );

endmodule

`default_nettype wire

// File: rtl/core/assm_checker.sv
// Port-level checks for the adaptive steering smoother, bound to the top level.
`default_nettype none

module assm_props #(
  parameter int unsigned STEER_WIDTH = 16
) (
  input wire                          clk_i,
  input wire                          rst_ni,
  input wire                          in_valid_i,
  input wire                          in_ready_o,
  input wire                          out_valid_o,
  input wire                          out_ready_i,
  input wire signed [STEER_WIDTH-1:0] smoothed_value_o
);

  // A waiting result stays offered.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped while stalled");

  // A waiting result holds its value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(smoothed_value_o))
    else $error("stalled result changed");

  // An accepted item keeps the input busy while it passes through the sequencer states.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o ##1 !in_ready_o)
    else $error("input ready too soon after an item");

  // A new result only appears at the end of a busy period.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(!in_ready_o))
    else $error("result appeared without an item at work");

endmodule

bind adaptive_steering_smoother assm_props #(
  .STEER_WIDTH(STEER_WIDTH)
) u_assm_props (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_valid_i      (in_valid_i),
  .in_ready_o      (in_ready_o),
  .out_valid_o     (out_valid_o),
  .out_ready_i     (out_ready_i),
  .smoothed_value_o(smoothed_value_o)
);

`default_nettype wire

// File: tb/assm_checker.sv
// Checker for the adaptive steering smoother: filter prediction and result comparison.
module assm_checker #(
  parameter int unsigned STEER_WIDTH    = 16,
  parameter int unsigned GAIN_FRAC_BITS = 16,
  parameter int unsigned CFG_WIDTH      = (GAIN_FRAC_BITS + 1 > STEER_WIDTH - 1) ?
                                          GAIN_FRAC_BITS + 1 : STEER_WIDTH - 1
) (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          in_valid_i,
  input  wire                          in_ready_i,
  input  wire signed [STEER_WIDTH-1:0] command_value_i,
  input  wire                          command_ok_i,
  input  wire signed [STEER_WIDTH-1:0] measured_value_i,
  input  wire                          measured_ok_i,
  input  wire                          seq_first_i,
  input  wire                          out_valid_i,
  input  wire                          out_ready_i,
  input  wire signed [STEER_WIDTH-1:0] smoothed_value_i,
  input  wire                          cfg_we_i,
  input  wire  [assm_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [CFG_WIDTH-1:0]         cfg_data_i,
  output int                           fail_count_o,
  output int                           pending_o
);

  localparam longint GAIN_ONE  = longint'(1) << GAIN_FRAC_BITS;
  localparam longint STEER_MAX = (longint'(1) << (STEER_WIDTH - 1)) - 1;
  localparam longint STEER_MIN = -(longint'(1) << (STEER_WIDTH - 1));

  // Register copies, loaded with the reset defaults of the block.
  longint gain_straight_q;
  longint gain_turn_q;
  longint turn_angle_q;

  // Filter state: last output, first output of the last sequence, and whether
  // any sequence has started since the last clear.
  longint running_q;
  longint seq_start_out_q;
  bit     history_q;

  // Smoothed values owed by the block, oldest first.
  logic signed [STEER_WIDTH-1:0] smoothed_due_q[$];

  function automatic longint magnitude(input longint v);
    return (v < 0) ? -v : v;
  endfunction

  // Runs one sample through the gain-blended low-pass filter and updates the state.
  task automatic filter_sample(input longint cmd, input bit cmd_ok, input longint meas,
                               input bit meas_ok, input bit seq_first, output longint res);
    longint prev, target, mag, ratio, blend, alpha, delta, step_mag;
    prev = running_q;
    if (seq_first) begin
      prev = history_q ? seq_start_out_q : (meas_ok ? meas : 0);
    end
    target = cmd_ok ? cmd : prev;
    mag = (magnitude(target) > magnitude(prev)) ? magnitude(target) : magnitude(prev);

    // Blend factor: magnitude over turn angle, capped at one.
    if (turn_angle_q == 0) begin
      ratio = GAIN_ONE;
    end else begin
      ratio = (mag << GAIN_FRAC_BITS) / turn_angle_q;
      if (ratio > GAIN_ONE) begin
        ratio = GAIN_ONE;
      end
    end
    blend = (gain_straight_q << GAIN_FRAC_BITS) + ratio * (gain_turn_q - gain_straight_q);
    if (blend < 0) begin
      blend = 0;
    end
    alpha = (blend + GAIN_ONE / 2) >> GAIN_FRAC_BITS;

    // Step toward the target, rounded to nearest with ties away from zero.
    delta = target - prev;
    step_mag = (alpha * magnitude(delta) + GAIN_ONE / 2) >> GAIN_FRAC_BITS;
    res = (delta < 0) ? prev - step_mag : prev + step_mag;
    if (res > STEER_MAX) begin
      res = STEER_MAX;
    end
    if (res < STEER_MIN) begin
      res = STEER_MIN;
    end

    running_q = res;
    if (seq_first) begin
      seq_start_out_q = res;
      history_q = 1'b1;
    end
  endtask

  // Follow register writes, check results, and predict each accepted item.
  always @(posedge clk_i or negedge rst_ni) begin : watch_channels
    longint res;
    bit cleared;
    logic signed [STEER_WIDTH-1:0] due;
    if (!rst_ni) begin
      gain_straight_q = 6554;
      gain_turn_q     = 32768;
      turn_angle_q    = 2048;
      running_q       = 0;
      seq_start_out_q = 0;
      history_q       = 1'b0;
      smoothed_due_q.delete();
      fail_count_o    = 0;
      pending_o       = 0;
    end else begin
      // A write to a known register also clears the filter state.
      if (cfg_we_i) begin
        cleared = 1'b1;
        case (cfg_index_i)
          assm_pkg::CFG_GAIN_STRAIGHT:
            gain_straight_q = longint'(cfg_data_i[GAIN_FRAC_BITS:0]);
          assm_pkg::CFG_GAIN_TURN:
            gain_turn_q     = longint'(cfg_data_i[GAIN_FRAC_BITS:0]);
          assm_pkg::CFG_TURN_ANGLE:
            turn_angle_q    = longint'(cfg_data_i[STEER_WIDTH-2:0]);
          default:
            cleared = 1'b0;
        endcase
        if (cleared) begin
          running_q       = 0;
          seq_start_out_q = 0;
          history_q       = 1'b0;
        end
      end

      // Each result is matched against the oldest prediction.
      if (out_valid_i && out_ready_i) begin
        if (smoothed_due_q.size() == 0) begin
          $error("smoothed_value: result with no item pending, actual %0d",
                 smoothed_value_i);
          fail_count_o++;
        end else begin
          due = smoothed_due_q.pop_front();
          if (smoothed_value_i !== due) begin
            $error("smoothed_value mismatch: expected %0d, actual %0d", due,
                   smoothed_value_i);
            fail_count_o++;
          end
        end
      end

      if (in_valid_i && in_ready_i) begin
        filter_sample(longint'(command_value_i), command_ok_i, longint'(measured_value_i),
                      measured_ok_i, seq_first_i, res);
        smoothed_due_q.push_back(STEER_WIDTH'(res));
      end

      pending_o = smoothed_due_q.size();
    end
  end

endmodule

// File: tb/testbench.sv
// Top of the smoother testbench: clock, reset, stimulus, handshake pacing and verdict.
module testbench;

  localparam int unsigned STEER_WIDTH    = 16;
  localparam int unsigned GAIN_FRAC_BITS = 16;
  localparam int unsigned CFG_WIDTH      = (GAIN_FRAC_BITS + 1 > STEER_WIDTH - 1) ?
                                           GAIN_FRAC_BITS + 1 : STEER_WIDTH - 1;
  localparam int unsigned LATENCY        = GAIN_FRAC_BITS + 5;
  localparam int unsigned STALL_LIMIT    = 2000;
  localparam int unsigned PHASE_ITEMS    = 75;

  logic                          clk_i;
  logic                          rst_ni           = 1'b0;
  logic                          in_valid_i       = 1'b0;
  logic                          in_ready_o;
  logic signed [STEER_WIDTH-1:0] command_value_i  = '0;
  logic                          command_ok_i     = 1'b0;
  logic signed [STEER_WIDTH-1:0] measured_value_i = '0;
  logic                          measured_ok_i    = 1'b0;
  logic                          seq_first_i      = 1'b0;
  logic                          out_valid_o;
  logic                          out_ready_i      = 1'b0;
  logic signed [STEER_WIDTH-1:0] smoothed_value_o;
  logic                          cfg_we_i         = 1'b0;
  logic [assm_pkg::CFG_IDX_W-1:0] cfg_index_i     = assm_pkg::CFG_GAIN_STRAIGHT;
  logic [CFG_WIDTH-1:0]          cfg_data_i       = '0;

  int fail_count;
  int pending;

  // Pacing controls: when set, the matching side never idles.
  bit tx_free;
  bit rx_free;
  int burst_left;
  int rx_run;
  bit rx_level;
  int stall_cycles;

  adaptive_steering_smoother #(
    .STEER_WIDTH   (STEER_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .command_value_i (command_value_i),
    .command_ok_i    (command_ok_i),
    .measured_value_i(measured_value_i),
    .measured_ok_i   (measured_ok_i),
    .seq_first_i     (seq_first_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .smoothed_value_o(smoothed_value_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i)
  );

  assm_checker #(
    .STEER_WIDTH   (STEER_WIDTH),
    .GAIN_FRAC_BITS(GAIN_FRAC_BITS),
    .CFG_WIDTH     (CFG_WIDTH)
  ) smoother_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_i      (in_ready_o),
    .command_value_i (command_value_i),
    .command_ok_i    (command_ok_i),
    .measured_value_i(measured_value_i),
    .measured_ok_i   (measured_ok_i),
    .seq_first_i     (seq_first_i),
    .out_valid_i     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .smoothed_value_i(smoothed_value_o),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .fail_count_o    (fail_count),
    .pending_o       (pending)
  );

  // Clock with a period of two time units.
  always begin
    clk_i = 1'b0;
    #1;
    clk_i = 1'b1;
    #1;
  end

  // Receiver: alternating runs of ready and stall cycles of random length.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
      rx_run = 0;
    end else if (rx_free) begin
      out_ready_i <= 1'b1;
    end else begin
      if (rx_run == 0) begin
        rx_level = !rx_level;
        if (rx_level) begin
          rx_run = $urandom_range(1, 20);
        end else begin
          rx_run = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 40) : $urandom_range(1, 6);
        end
      end
      rx_run--;
      out_ready_i <= rx_level;
    end
  end

  // Watchdog: ends the run when no channel has moved for too long.
  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || cfg_we_i) begin
      stall_cycles = 0;
    end else begin
      stall_cycles++;
    end
    if (stall_cycles >= STALL_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Offers one item, inserting a random gap at the end of each burst.
  task automatic send_item(input logic signed [STEER_WIDTH-1:0] cmd, input bit cmd_ok,
                           input logic signed [STEER_WIDTH-1:0] meas, input bit meas_ok,
                           input bit seq_first);
    int gap;
    if (!tx_free && burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 12);
    end
    in_valid_i       <= 1'b1;
    command_value_i  <= cmd;
    command_ok_i     <= cmd_ok;
    measured_value_i <= meas;
    measured_ok_i    <= meas_ok;
    seq_first_i      <= seq_first;
    do @(posedge clk_i); while (!in_ready_o);
    if (burst_left > 0) begin
      burst_left--;
    end
  endtask

  // Stops offering items and waits until every predicted result has been taken.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    burst_left = 0;
    do @(negedge clk_i); while (pending != 0);
    @(posedge clk_i);
  endtask

  // Writes all three registers on consecutive cycles; the block must be idle.
  task automatic configure(input int unsigned gs, input int unsigned gt,
                           input int unsigned ta);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= assm_pkg::CFG_GAIN_STRAIGHT;
    cfg_data_i  <= CFG_WIDTH'(gs);
    @(posedge clk_i);
    cfg_index_i <= assm_pkg::CFG_GAIN_TURN;
    cfg_data_i  <= CFG_WIDTH'(gt);
    @(posedge clk_i);
    cfg_index_i <= assm_pkg::CFG_TURN_ANGLE;
    cfg_data_i  <= CFG_WIDTH'(ta);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  // Picks a command angle: full range, near zero, a ramp from the last one, an extreme, or within +/-6000.
  function automatic logic signed [STEER_WIDTH-1:0] pick_angle(
      input logic signed [STEER_WIDTH-1:0] last);
    int v;
    case ($urandom_range(0, 5))
      0: return STEER_WIDTH'($urandom);
      1: v = int'($urandom_range(0, 1023)) - 512;
      2: v = int'(last) + int'($urandom_range(0, 800)) - 400;
      3: begin
        case ($urandom_range(0, 3))
          0: v = -32768;
          1: v = 32767;
          2: v = 0;
          default: v = -1;
        endcase
      end
      default: v = int'($urandom_range(0, 12000)) - 6000;
    endcase
    if (v > 32767) begin
      v = 32767;
    end
    if (v < -32768) begin
      v = -32768;
    end
    return STEER_WIDTH'(v);
  endfunction

  // Random sequences, mostly well formed; a few carry stray or missing first marks.
  task automatic random_phase(input int n);
    int sent;
    int seq_len;
    bit broken;
    bit mark;
    logic signed [STEER_WIDTH-1:0] last_cmd;
    sent = 0;
    last_cmd = '0;
    while (sent < n) begin
      seq_len = $urandom_range(1, 12);
      broken = ($urandom_range(0, 9) == 0);
      for (int k = 0; k < seq_len && sent < n; k++) begin
        mark = (k == 0);
        if (broken) begin
          mark = 1'($urandom_range(0, 1));
        end
        last_cmd = pick_angle(last_cmd);
        send_item(last_cmd, $urandom_range(0, 9) != 0, STEER_WIDTH'($urandom),
                  1'($urandom_range(0, 1)), mark);
        sent++;
      end
    end
    drain_results();
  endtask

  initial begin : stimulus
    int unsigned gs;
    tx_free = 1'b0;
    rx_free = 1'b0;
    burst_left = 0;
    stall_cycles = 0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset defaults: an unmarked sample before any sequence, a start from the
    // measured angle, a held command, and a restart from the saved first output.
    send_item(16'sd1000, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sh7fff, 1'b1, 16'sh8000, 1'b1, 1'b1);
    send_item(16'sh8000, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0);
    send_item(16'sh8000, 1'b1, 16'sh7fff, 1'b1, 1'b1);
    send_item(16'sh7fff, 1'b1, 16'sh7fff, 1'b1, 1'b0);
    drain_results();

    // A write clears the history: a first sample with no valid measurement starts at zero.
    configure(6554, 32768, 2048);
    send_item(16'sd500, 1'b1, 16'sd1234, 1'b0, 1'b1);
    send_item(-16'sd500, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd0, 1'b0, 16'sd0, 1'b1, 1'b1);
    drain_results();

    // Zero turn angle: the turn gain applies throughout.
    configure(0, 65536, 0);
    send_item(16'sd20000, 1'b1, -16'sd20000, 1'b1, 1'b1);
    send_item(16'sh8000, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd0, 1'b0, 16'sd0, 1'b0, 1'b0);
    drain_results();

    // Straight gain above the turn gain, with the smallest turn angle.
    configure(65536, 0, 1);
    send_item(16'sd100, 1'b1, 16'sd0, 1'b0, 1'b1);
    send_item(16'sh7fff, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sh8000, 1'b1, 16'sd0, 1'b0, 1'b0);
    drain_results();

    // Gains well above one overshoot, so the output saturates at both ends.
    configure(131071, 131071, 32767);
    send_item(16'sh7fff, 1'b1, 16'sh8000, 1'b1, 1'b1);
    send_item(16'sh8000, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sh7fff, 1'b1, 16'sd0, 1'b0, 1'b0);
    send_item(16'sd0, 1'b1, 16'sd0, 1'b0, 1'b1);
    drain_results();

    // Random phases across register settings, extremes first.
    configure(6554, 32768, 2048);
    random_phase(PHASE_ITEMS);
    configure(0, 0, 1);
    random_phase(PHASE_ITEMS);
    configure(65536, 65536, 32767);
    random_phase(PHASE_ITEMS);
    tx_free = 1'b1;
    rx_free = 1'b1;
    configure(0, 65536, 1);
    random_phase(PHASE_ITEMS);
    tx_free = 1'b0;
    rx_free = 1'b0;
    configure(65536, 0, 2048);
    random_phase(PHASE_ITEMS);
    configure(3000, 50000, 0);
    random_phase(PHASE_ITEMS);
    configure(131071, 100000, 4096);
    random_phase(PHASE_ITEMS);
    for (int p = 0; p < 3; p++) begin
      gs = $urandom_range(0, 65536);
      configure(gs, $urandom_range(gs, 65536), $urandom_range(1, 32767));
      random_phase(PHASE_ITEMS);
    end

    // Let any stray result show up before the verdict.
    repeat (2 * LATENCY) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
